// File: rtl/core/gwrm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwrm_pkg
// Shared types and constants of the gain stage with RMS level meter.
// ----------------------------------------------------------------------------
package gwrm_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 12;
    localparam int FRAME_W    = 13;
    localparam int MAX_FRAME  = 4096;
    localparam int CHAN_W     = 5;
    localparam int MAX_CHAN   = 16;
    localparam int SIDX_W     = 12;
    localparam int CIDX_W     = 4;
    localparam int SUM_W      = 44;
    localparam int PROD_W     = 32;
    localparam int MAG_W      = SAMPLE_W + 1;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int DREM_W     = FRAME_W - 1;
    localparam int SREM_W     = ROOT_W + 1;
    localparam int DIV_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int OUT_DATA_W = 56;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN          = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RMS_ENABLE    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SAMPLES = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 8'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_SAT,
        ST_SQ_IN,
        ST_SQ_OUT,
        ST_ACC_OUT,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        MUL_GAIN,
        MUL_IN,
        MUL_OUT
    } t_mul_sel;

    typedef struct packed {
        logic     load_x;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sat_en;
        logic     acc_in;
        logic     acc_out;
        logic     div_init;
        logic     div_step;
        logic     sqrt_step;
        logic     out_load;
        logic     end_item;
    } t_dp_cmd;

    typedef struct packed {
        logic meter_end;
        logic out_free;
    } t_dp_status;

endpackage

// File: rtl/core/gwrm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwrm_ctrl
// Sequencer: steps one sample through multiply, saturate, square and
// accumulate, and through divide and root at a metered channel end.
// ----------------------------------------------------------------------------
module gwrm_ctrl
    import gwrm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            ST_IDLE:     if (i_in_valid) n_state = ST_MUL;
            ST_MUL:      n_state = ST_SAT;
            ST_SAT:      n_state = ST_SQ_IN;
            ST_SQ_IN:    n_state = ST_SQ_OUT;
            ST_SQ_OUT:   n_state = ST_ACC_OUT;
            ST_ACC_OUT:  n_state = i_status.meter_end ? ST_DIV_INIT : ST_DONE;
            ST_DIV_INIT: begin
                n_state = ST_DIV;
                n_cnt   = CNT_W'(DIV_STEPS - 1);
            end
            ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = ST_SQRT;
                    n_cnt   = CNT_W'(SQRT_STEPS - 1);
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SQRT: begin
                if (r_cnt == '0) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_DONE:     if (i_status.out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_GAIN;
        o_in_ready    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.load_x = i_in_valid;
            end
            ST_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_GAIN;
            end
            ST_SAT:      o_cmd.sat_en = 1'b1;
            ST_SQ_IN: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_IN;
            end
            ST_SQ_OUT: begin
                o_cmd.acc_in  = 1'b1;
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_OUT;
            end
            ST_ACC_OUT:  o_cmd.acc_out   = 1'b1;
            ST_DIV_INIT: o_cmd.div_init  = 1'b1;
            ST_DIV:      o_cmd.div_step  = 1'b1;
            ST_SQRT:     o_cmd.sqrt_step = 1'b1;
            ST_DONE: begin
                o_cmd.out_load = i_status.out_free;
                o_cmd.end_item = i_status.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

endmodule

// File: rtl/core/gwrm_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwrm_dp
// Datapath: configuration registers, shared multiplier, square sums,
// frame counters, bit-serial dividers and roots, output register.
// ----------------------------------------------------------------------------
module gwrm_dp
    import gwrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_user
);

    // configuration
    logic signed [GAIN_W-1:0] r_gain;
    logic                     r_rms_en;
    logic [FRAME_W-1:0]       r_frame;
    logic [CHAN_W-1:0]        r_chans;

    // per-sample work registers
    logic signed [SAMPLE_W-1:0] r_x;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [SAMPLE_W-1:0] r_q;
    logic                       r_sat;
    logic [MAG_W-1:0]           r_ax, r_aq;

    // frame state
    logic [SIDX_W-1:0] r_sidx;
    logic [CIDX_W-1:0] r_cidx;
    logic [SUM_W-1:0]  r_sum  [2];

    // divide and root lanes: 0 input, 1 output
    logic [SUM_W-1:0]  r_quot [2];
    logic [DREM_W-1:0] r_drem [2];
    logic [SREM_W-1:0] r_srem [2];
    logic [ROOT_W-1:0] r_root [2];

    logic                      r_out_valid;
    logic [OUT_DATA_W-1:0]     r_out_data;
    logic                      r_out_user;

    logic [FRAME_W-1:0] len_eff;
    logic [CHAN_W-1:0]  chans_eff;
    logic               last_sample, last_chan;

    logic signed [MAG_W-1:0]     op_a, op_b;
    logic signed [2*MAG_W-1:0]   prod;
    logic signed [PROD_W-1:0]    q_wide;
    logic signed [SAMPLE_W-1:0]  q_sat;
    logic                        sat_flag;
    logic signed [MAG_W-1:0]     x_ext, q_ext;

    logic [FRAME_W-1:0]  drem_sh  [2];
    logic                dge      [2];
    logic [SREM_W+1:0]   srem_sh  [2];
    logic [SREM_W+1:0]   trial    [2];
    logic                sge      [2];

    localparam logic signed [PROD_W-1:0] SMAX = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SMIN = -SMAX - PROD_W'(1);

    // clamp the frame length and channel count to their legal ranges
    always_comb begin
        if (r_frame == '0) begin
            len_eff = FRAME_W'(1);
        end else if (r_frame > FRAME_W'(MAX_FRAME)) begin
            len_eff = FRAME_W'(MAX_FRAME);
        end else begin
            len_eff = r_frame;
        end
        if (r_chans == '0) begin
            chans_eff = CHAN_W'(1);
        end else if (r_chans > CHAN_W'(MAX_CHAN)) begin
            chans_eff = CHAN_W'(MAX_CHAN);
        end else begin
            chans_eff = r_chans;
        end
    end

    assign last_sample = ({1'b0, r_sidx} + FRAME_W'(1)) >= len_eff;
    assign last_chan   = ({1'b0, r_cidx} + CHAN_W'(1)) >= chans_eff;

    assign o_status.meter_end = last_sample && r_rms_en;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // shared multiplier
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_GAIN: begin
                op_a = MAG_W'(r_x);
                op_b = MAG_W'(r_gain);
            end
            MUL_IN: begin
                op_a = r_ax;
                op_b = r_ax;
            end
            MUL_OUT: begin
                op_a = r_aq;
                op_b = r_aq;
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end
    assign prod = op_a * op_b;

    // floor shift and saturation
    always_comb begin
        q_wide   = r_prod >>> GAIN_FRAC;
        sat_flag = 1'b0;
        q_sat    = SAMPLE_W'(q_wide);
        if (q_wide > SMAX) begin
            q_sat    = SAMPLE_W'(SMAX);
            sat_flag = 1'b1;
        end else if (q_wide < SMIN) begin
            q_sat    = SAMPLE_W'(SMIN);
            sat_flag = 1'b1;
        end
        x_ext = MAG_W'(r_x);
        q_ext = MAG_W'(q_sat);
    end

    // one restoring divide step and one root step per lane
    always_comb begin
        for (int j = 0; j < 2; j++) begin
            drem_sh[j] = {r_drem[j], r_quot[j][SUM_W-1]};
            dge[j]     = drem_sh[j] >= len_eff;
            srem_sh[j] = {r_srem[j], r_quot[j][SUM_W-1:SUM_W-2]};
            trial[j]   = {1'b0, r_root[j], 2'b01};
            sge[j]     = srem_sh[j] >= trial[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_W'(1 << GAIN_FRAC);
            r_rms_en <= 1'b0;
            r_frame  <= FRAME_W'(512);
            r_chans  <= CHAN_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAIN:          r_gain   <= GAIN_W'(i_cfg_data);
                CFG_RMS_ENABLE:    r_rms_en <= i_cfg_data[0];
                CFG_FRAME_SAMPLES: r_frame  <= i_cfg_data[FRAME_W-1:0];
                CFG_CHANNEL_COUNT: r_chans  <= i_cfg_data[CHAN_W-1:0];
                default:           r_rms_en <= r_rms_en;
            endcase
        end
    end

    // work registers need no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_x) begin
            r_x <= i_sample;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(prod);
        end
        if (i_cmd.sat_en) begin
            r_q   <= q_sat;
            r_sat <= sat_flag;
            r_ax  <= (x_ext < 0) ? -x_ext : x_ext;
            r_aq  <= (q_ext < 0) ? -q_ext : q_ext;
        end
        for (int j = 0; j < 2; j++) begin
            if (i_cmd.div_init) begin
                r_quot[j] <= r_sum[j];
                r_drem[j] <= '0;
                r_srem[j] <= '0;
                r_root[j] <= '0;
            end else if (i_cmd.div_step) begin
                r_quot[j] <= {r_quot[j][SUM_W-2:0], dge[j]};
                r_drem[j] <= dge[j] ? DREM_W'(drem_sh[j] - len_eff)
                                    : DREM_W'(drem_sh[j]);
            end else if (i_cmd.sqrt_step) begin
                r_quot[j] <= {r_quot[j][SUM_W-3:0], 2'b00};
                r_srem[j] <= sge[j] ? SREM_W'(srem_sh[j] - trial[j])
                                    : SREM_W'(srem_sh[j]);
                r_root[j] <= {r_root[j][ROOT_W-2:0], sge[j]};
            end
        end
        if (i_cmd.out_load) begin
            r_out_user <= o_status.meter_end;
            if (o_status.meter_end) begin
                r_out_data <= {3'b000, r_root[1][SAMPLE_W-1:0], r_root[0][SAMPLE_W-1:0],
                               r_cidx, r_sat, r_q};
            end else begin
                r_out_data <= {39'd0, r_sat, r_q};
            end
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sidx   <= '0;
            r_cidx   <= '0;
            r_sum[0] <= '0;
            r_sum[1] <= '0;
        end else begin
            if (i_cmd.acc_in && r_rms_en) begin
                r_sum[0] <= r_sum[0] + SUM_W'(unsigned'(r_prod));
            end
            if (i_cmd.acc_out && r_rms_en) begin
                r_sum[1] <= r_sum[1] + SUM_W'(unsigned'(r_prod));
            end
            if (i_cmd.end_item) begin
                if (last_sample) begin
                    r_sidx   <= '0;
                    r_sum[0] <= '0;
                    r_sum[1] <= '0;
                    r_cidx   <= last_chan ? '0 : r_cidx + 1'b1;
                end else begin
                    r_sidx <= r_sidx + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_user  = r_out_user;

endmodule

// File: rtl/core/gain_with_rms_meter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gain_with_rms_meter_top
// Audio gain stage with saturation and a per-channel RMS level meter.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                    payload
//  -------   ---------  ---------------------------  ---------------------------
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: sample
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: gained sample, meter
//                                                    tuser: rms_valid
//  cfg       in         i_cfg_valid/o_cfg_ready      index, write data
//
//  A sample passes from its input transfer through multiply, saturate, square
//  and accumulate into the output register, and the input takes no new sample
//  until the last one is loaded there: the single shared 17x17 multiplier forms
//  the gain product and both squares in turn. At the last sample of a metered
//  channel the setup state, the bit-serial dividers and square roots run first.
//  Reset is synchronous and active low; it restores the register defaults and
//  clears counters and square sums. A stalled result holds in the output
//  register while the next sample is already taken in and processed.
// ----------------------------------------------------------------------------
module gain_with_rms_meter_top
    import gwrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] sample
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [15:0] out_sample, [16] out_saturated, [20:17] rms_channel,
    // [36:21] in_rms, [52:37] out_rms, [55:53] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [0] rms_valid
    output logic                  m_axis_tuser,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // registers accept a write in every cycle
    assign o_cfg_ready = 1'b1;

    // sequencer: issues one command set per cycle
    gwrm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    // datapath: multiply, saturate, accumulate, divide, root, output register
    gwrm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_sample    (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the audio gain stage with per-channel RMS meter.
// Drives samples and register writes, predicts every result with an internal
// model of the gain, clip and meter math, and compares each output transfer
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
    import gwrm_pkg::*;

    // Quiet cycles before the run is declared hung. This is well above the
    // output hold-off plus the longest sender gap plus the path of a sample
    // that closes a metered channel.
    localparam int WATCHDOG_LIMIT = 3000;
    // Idle time after the last result before a register write or the end.
    // Covers the sample path and the divide/root tail.
    localparam int DRAIN_PAUSE    = 80;
    localparam int RANDOM_ITEMS   = 320;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int MAX_PRINTED    = 30;

    // Index outside the register map; the block must ignore the write.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 8'hFF;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    // One predicted output transfer
    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                clipped;
        logic                meter_valid;
        logic [CIDX_W-1:0]   meter_channel;
        logic [15:0]         in_level;
        logic [15:0]         out_level;
    } t_gain_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow registers and running state of the predictor
    logic signed [GAIN_W-1:0] gain_q412;
    logic                     meter_on;
    logic [FRAME_W-1:0]       frame_len_reg;
    logic [CHAN_W-1:0]        chan_count_reg;
    int unsigned              chan_pos;
    int unsigned              sample_pos;
    logic [SUM_W-1:0]         in_energy;
    logic [SUM_W-1:0]         out_energy;

    t_gain_result pending_outputs[$];

    // Stimulus knobs; sink_stalls and hold_off_request are shared with the ready process
    bit source_gaps;
    bit sink_stalls;
    bit hold_off_request;

    int samples_sent;
    int results_seen;
    int meter_reports;
    int clipped_count;
    int cfg_writes;
    int errors;

    gain_with_rms_meter_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    function automatic int unsigned frame_len_eff();
        if (frame_len_reg == 0) return 1;
        if (frame_len_reg > MAX_FRAME) return MAX_FRAME;
        return frame_len_reg;
    endfunction

    function automatic int unsigned chans_eff();
        if (chan_count_reg == 0) return 1;
        if (chan_count_reg > MAX_CHAN) return MAX_CHAN;
        return chan_count_reg;
    endfunction

    // Bit-by-bit floor square root, widest root that a 44-bit sum can give
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int b = SUM_W / 2; b >= 0; b--) begin
            t = r | (longint'(1) << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    // Advance the predictor by one accepted sample and return its output
    function automatic t_gain_result gain_and_meter_step(logic [SAMPLE_W-1:0] raw);
        t_gain_result    res;
        longint          x;
        longint          q;
        longint unsigned len;
        res = '0;
        len = frame_len_eff();
        x   = longint'($signed(raw));
        // arithmetic shift of the Q4.12 product floors toward minus infinity
        q   = (x * longint'(gain_q412)) >>> GAIN_FRAC;
        if (q > SAMPLE_MAX) begin
            q = SAMPLE_MAX;
            res.clipped = 1'b1;
        end else if (q < SAMPLE_MIN) begin
            q = SAMPLE_MIN;
            res.clipped = 1'b1;
        end
        res.sample = q[SAMPLE_W-1:0];

        // sums wrap at 44 bits
        if (meter_on) begin
            in_energy  = SUM_W'(in_energy + x * x);
            out_energy = SUM_W'(out_energy + q * q);
        end

        // a position at or past the current length closes the channel
        if (sample_pos + 1 >= len) begin
            if (meter_on) begin
                res.meter_valid   = 1'b1;
                res.meter_channel = chan_pos[CIDX_W-1:0];
                res.in_level      = 16'(floor_root(in_energy / len));
                res.out_level     = 16'(floor_root(out_energy / len));
            end
            in_energy  = '0;
            out_energy = '0;
            sample_pos = 0;
            if (chan_pos + 1 >= chans_eff()) chan_pos = 0;
            else chan_pos++;
        end else begin
            sample_pos++;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Random values
    // ------------------------------------------------------------------------

    // Mostly short, now and then medium, rarely long
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int source_gap();
        if (!source_gaps || $urandom_range(0, 99) < 55) return 0;
        return random_gap();
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 4))
            0: if (r < 15) return 16'h7FFF;
            1: if (r < 15) return 16'h8000;
            2: if (r < 15) return 16'hFFFF;
            default: ;
        endcase
        if (r < 35) return 16'($signed($urandom_range(0, 512)) - 256);
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [GAIN_W-1:0] random_gain();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return 16'h8000;
        if (r < 8) return 16'h7FFF;
        if (r < 11) return 16'h0000;
        if (r < 15) return 16'h1000;
        if (r < 50) begin
            if ($urandom_range(0, 1)) return 16'($urandom_range(2048, 12288));
            return 16'(-$signed($urandom_range(2048, 12288)));
        end
        return 16'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_frame();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 16'($urandom_range(1, 6));
        if (r < 88) return 16'($urandom_range(7, 40));
        if (r < 94) return 16'd0;
        return 16'($urandom_range(MAX_FRAME + 1, 8191));
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_chans();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 16'($urandom_range(1, MAX_CHAN));
        if (r < 90) return 16'd0;
        return 16'($urandom_range(MAX_CHAN + 1, 31));
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Offer one sample, hold it until the transfer, then record the prediction.
    // tvalid stays high between back-to-back samples.
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        gap = source_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_outputs.push_back(gain_and_meter_step(value));
        samples_sent++;
    endtask

    // Write one register; the shadow copy follows at the transfer
    task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (reg_index)
            CFG_GAIN:          gain_q412      = value;
            CFG_RMS_ENABLE:    meter_on       = value[0];
            CFG_FRAME_SAMPLES: frame_len_reg  = value[FRAME_W-1:0];
            CFG_CHANNEL_COUNT: chan_count_reg = value[CHAN_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] gain_val,
                             input logic                  enable,
                             input logic [CFG_DATA_W-1:0] frame_val,
                             input logic [CFG_DATA_W-1:0] chans_val);
        write_register(CFG_GAIN, gain_val);
        write_register(CFG_RMS_ENABLE, {15'd0, enable});
        write_register(CFG_FRAME_SAMPLES, frame_val);
        write_register(CFG_CHANNEL_COUNT, chans_val);
    endtask

    // Drop tvalid, wait for every predicted result, then let the block go idle
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_PAUSE) @(posedge i_clk);
    endtask

    // Output ready: random stalls when enabled, one long hold-off on request
    initial begin : sink_ready
        int stall;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_request) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_LEN - 1) @(negedge i_clk);
                hold_off_request = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 99) < 30) begin
                stall = random_gap();
                m_axis_tready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input longint want, input longint got);
        errors++;
        if (errors <= MAX_PRINTED)
            $display("mismatch at result %0d: %s want 0x%0h got 0x%0h",
                     results_seen, what, want, got);
    endtask

    // Compare one output transfer with the oldest prediction
    task automatic check_result();
        t_gain_result want;
        results_seen++;
        if (pending_outputs.size() == 0) begin
            report_mismatch("result with nothing pending", 0, m_axis_tdata);
            return;
        end
        want = pending_outputs.pop_front();
        if (want.meter_valid) meter_reports++;
        if (want.clipped) clipped_count++;
        if (m_axis_tdata[15:0] !== want.sample)
            report_mismatch("out_sample", want.sample, m_axis_tdata[15:0]);
        if (m_axis_tdata[16] !== want.clipped)
            report_mismatch("out_saturated", want.clipped, m_axis_tdata[16]);
        if (m_axis_tuser !== want.meter_valid)
            report_mismatch("rms_valid", want.meter_valid, m_axis_tuser);
        if (m_axis_tdata[20:17] !== want.meter_channel)
            report_mismatch("rms_channel", want.meter_channel, m_axis_tdata[20:17]);
        if (m_axis_tdata[36:21] !== want.in_level)
            report_mismatch("in_rms", want.in_level, m_axis_tdata[36:21]);
        if (m_axis_tdata[52:37] !== want.out_level)
            report_mismatch("out_rms", want.out_level, m_axis_tdata[52:37]);
        if (m_axis_tdata[55:53] !== 3'd0)
            report_mismatch("tdata padding", 0, m_axis_tdata[55:53]);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) check_result();
    end

    // Abort when no transfer of any kind happens for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 quiet, pending_outputs.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values: unity gain, metering off, no clipping possible
    task automatic test_unity_default();
        send_sample(16'h7FFF);
        send_sample(16'h1F40);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
    endtask

    // Most negative and most positive gain, zero gain, and floor rounding
    task automatic test_gain_extremes();
        settle();
        write_register(CFG_GAIN, 16'h8000);
        send_sample(16'h7FFF);  // clips low
        send_sample(16'h8000);  // clips high
        settle();
        write_register(CFG_GAIN, 16'h7FFF);
        send_sample(16'h0001);
        send_sample(16'hFFFF);  // floors to -8
        settle();
        write_register(CFG_GAIN, 16'hFFFF);
        send_sample(16'h0001);  // tiny negative product floors to -1
        settle();
        write_register(CFG_GAIN, 16'h0000);
        send_sample(16'h8000);
    endtask

    // Two channels of two samples with metering on
    task automatic test_meter_basic();
        settle();
        // flush the position left by earlier tests with a one-sample frame
        configure(16'h2000, 1'b0, 16'd1, 16'd1);
        send_sample(16'h0000);
        settle();
        configure(16'h2000, 1'b1, 16'd2, 16'd2);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0100);
        send_sample(16'hFF00);
    endtask

    // Zero frame length and zero channel count act as one
    task automatic test_length_clamps();
        settle();
        write_register(CFG_FRAME_SAMPLES, 16'd0);
        write_register(CFG_CHANNEL_COUNT, 16'd0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
    endtask

    // Metering off adds nothing, sums still clear at the channel end
    task automatic test_meter_disabled();
        settle();
        configure(16'h1000, 1'b0, 16'd3, 16'd1);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        settle();
        write_register(CFG_RMS_ENABLE, 16'd1);
        send_sample(16'h4000);
    endtask

    // Shrink the frame and the channel count below the current positions
    task automatic test_mid_frame_change();
        settle();
        configure(16'h1000, 1'b1, 16'(MAX_FRAME), 16'd2);
        repeat (5) send_sample(16'h8000);
        settle();
        write_register(CFG_FRAME_SAMPLES, 16'd2);  // position 5 closes channel 0
        send_sample(16'h7FFF);
        send_sample(16'h0001);
        send_sample(16'hFFFE);
        settle();
        write_register(CFG_FRAME_SAMPLES, 16'd1);
        write_register(CFG_CHANNEL_COUNT, 16'd3);
        send_sample(16'h1234);
        send_sample(16'hEDCC);
        settle();
        write_register(CFG_CHANNEL_COUNT, 16'd2);  // channel 2 reports, then wraps
        send_sample(16'h5555);
    endtask

    // A write outside the register map changes nothing
    task automatic test_unmapped_register();
        settle();
        write_register(CFG_UNMAPPED, 16'hFFFF);
        send_sample(16'hAAAA);
        send_sample(16'h5555);
    endtask

    // Hold the output off long enough that the input stalls, then drain
    task automatic test_backpressure();
        settle();
        configure(random_gain(), 1'b1, 16'd1, 16'(MAX_CHAN));
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        hold_off_request = 1'b1;
        repeat (24) send_sample(random_sample());
    endtask

    // Oversize lengths clamp to the largest one and must not close the
    // channel early; shrink the length afterwards to close it
    task automatic test_long_frame();
        settle();
        source_gaps = 1'b0;
        sink_stalls = 1'b0;
        configure(16'h7FFF, 1'b1, 16'(MAX_FRAME + 1), 16'd1);
        repeat (30) send_sample(random_sample());
        settle();
        write_register(CFG_FRAME_SAMPLES, 16'd8191);
        repeat (30) send_sample(random_sample());
        settle();
        write_register(CFG_FRAME_SAMPLES, 16'd61);  // position 60 closes the channel
        send_sample(random_sample());
    endtask

    // Random settings per phase; most phases send whole frames
    task automatic test_random_phases();
        int sent;
        int n;
        int per_frame;
        int phase;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            // pause until every result is back before touching registers
            settle();
            if (phase == 0)
                configure(random_gain(), 1'b1, 16'd1, 16'd31);  // channel clamp to 16
            else
                configure(random_gain(), $urandom_range(0, 99) < 75, random_frame(),
                          random_chans());
            source_gaps = ($urandom_range(0, 99) < 70);
            sink_stalls = ($urandom_range(0, 99) < 70);
            per_frame = frame_len_eff() * chans_eff();
            if (per_frame > 60) begin
                n = $urandom_range(20, 40);
            end else begin
                n = per_frame;
                while (n < 24) n += per_frame;
            end
            // now and then break the frame with a few stray samples
            if ($urandom_range(0, 99) < 20) n += $urandom_range(1, 3);
            repeat (n) send_sample(random_sample());
            sent += n;
            phase++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n          = 1'b0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        i_cfg_valid      = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        source_gaps      = 1'b1;
        sink_stalls      = 1'b1;
        hold_off_request = 1'b0;
        samples_sent     = 0;
        results_seen     = 0;
        meter_reports    = 0;
        clipped_count    = 0;
        cfg_writes       = 0;
        errors           = 0;

        gain_q412      = 16'sd4096;
        meter_on       = 1'b0;
        frame_len_reg  = 13'd512;
        chan_count_reg = 5'd1;
        chan_pos       = 0;
        sample_pos     = 0;
        in_energy      = '0;
        out_energy     = '0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_unity_default();
        test_gain_extremes();
        test_meter_basic();
        test_length_clamps();
        test_meter_disabled();
        test_mid_frame_change();
        test_unmapped_register();
        test_backpressure();
        test_long_frame();
        test_random_phases();
        settle();

        if (pending_outputs.size() != 0)
            report_mismatch("results never delivered", 0, pending_outputs.size());

        $display("Run covered %0d samples and %0d output transfers, %0d with meter values",
                 samples_sent, results_seen, meter_reports);
        $display("%0d clipped outputs, %0d register writes over gain, enable, length, channels",
                 clipped_count, cfg_writes);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/gwrm_pkg.sv
rtl/core/gwrm_ctrl.sv
rtl/core/gwrm_dp.sv
rtl/core/gain_with_rms_meter_top.sv
tb/tb.sv
